### rtl/core/tpss_pkg.sv
// Shared types, item codes and constant tables for the two-pose servo
// playback sequencer. No dependencies; imported by every module of the block.
package tpss_pkg;

  // Item kinds carried on the slave-side tuser
  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_MOVE  = 3'd1;
  localparam logic [2:0] KIND_SAVE  = 3'd2;
  localparam logic [2:0] KIND_START = 3'd3;
  localparam logic [2:0] KIND_STOP  = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOOK_DELAY = 2'd1;

  localparam logic [15:0] STEP_DELAY_RST = 16'd500;
  localparam logic [15:0] HOOK_DELAY_RST = 16'd1000;
  localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;
  localparam logic [7:0]  ANGLE_MAX      = 8'd180;

  // Joint codes
  localparam logic [1:0] JOINT_BASE     = 2'd0;
  localparam logic [1:0] JOINT_ELEVATOR = 2'd1;
  localparam logic [1:0] JOINT_CRANE    = 2'd2;
  localparam logic [1:0] JOINT_HOOK     = 2'd3;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  // One result item on its way to the output register
  typedef struct packed {
    logic       valid;
    logic [1:0] joint;
    logic [7:0] angle;
  } result_t;

  // Home angle of each joint, indexed by joint code
  function automatic logic [7:0] home_angle(input logic [1:0] joint);
    logic [7:0] a;
    unique case (joint)
      JOINT_BASE:     a = 8'd90;
      JOINT_ELEVATOR: a = 8'd25;
      JOINT_CRANE:    a = 8'd145;
      JOINT_HOOK:     a = 8'd25;
      default:        a = 8'd90;
    endcase
    return a;
  endfunction

  // Joint served by each playback step: base, crane, elevator, hook
  function automatic logic [1:0] step_joint(input logic [1:0] step);
    logic [1:0] j;
    unique case (step)
      2'd0:    j = JOINT_BASE;
      2'd1:    j = JOINT_CRANE;
      2'd2:    j = JOINT_ELEVATOR;
      2'd3:    j = JOINT_HOOK;
      default: j = JOINT_BASE;
    endcase
    return j;
  endfunction

endpackage

### rtl/core/tpss_core.sv
// Sequencer state, delay registers and the per-item update for the playback
// sequencer. Depends on tpss_pkg; one item is processed whenever go is high.
module tpss_core
  import tpss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [2:0]           kind,
  input  logic [1:0]           joint,
  input  logic [7:0]           angle,
  input  logic                 pose_sel,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]          cfg_wdata,
  output result_t              res
);

  logic [15:0] step_delay;
  logic [15:0] hook_delay;
  logic [7:0]  current_angles [4];
  logic [7:0]  pose_store [8];
  logic        running;
  logic [1:0]  step_index;
  logic        toward_a;
  logic [15:0] elapsed;

  logic [15:0] elapsed_inc;
  logic [15:0] delay_sel;
  logic        step_due;
  logic [1:0]  play_joint;
  logic [2:0]  play_addr;
  logic [7:0]  move_angle;

  // Playback timing for a tick
  always_comb begin
    elapsed_inc = (elapsed == ELAPSED_MAX) ? elapsed : elapsed + 16'd1;
    delay_sel   = (step_index == 2'd3) ? hook_delay : step_delay;
    step_due    = (elapsed_inc >= delay_sel);
    play_joint  = step_joint(step_index);
    play_addr   = {~toward_a, play_joint};
    move_angle  = (angle > ANGLE_MAX) ? ANGLE_MAX : angle;
  end

  // Result of the item being processed
  always_comb begin
    res = '0;
    if (go) begin
      if (kind == KIND_MOVE) begin
        res.valid = 1'b1;
        res.joint = joint;
        res.angle = move_angle;
      end else if (kind == KIND_TICK && running && step_due) begin
        res.valid = 1'b1;
        res.joint = play_joint;
        res.angle = pose_store[play_addr];
      end
    end
  end

  // Delay registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_delay <= STEP_DELAY_RST;
      hook_delay <= HOOK_DELAY_RST;
    end else if (cfg_we) begin
      if (cfg_idx == REG_STEP_DELAY) step_delay <= cfg_wdata;
      if (cfg_idx == REG_HOOK_DELAY) hook_delay <= cfg_wdata;
    end
  end

  // Playback control state
  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      step_index <= 2'd0;
      toward_a   <= 1'b1;
      elapsed    <= 16'd0;
    end else if (go) begin
      unique case (kind)
        KIND_TICK: begin
          if (running) begin
            if (step_due) begin
              elapsed    <= 16'd0;
              step_index <= step_index + 2'd1;
              if (step_index == 2'd3) toward_a <= ~toward_a;
            end else begin
              elapsed <= elapsed_inc;
            end
          end
        end
        KIND_START: begin
          running    <= 1'b1;
          step_index <= 2'd0;
          toward_a   <= 1'b1;
          elapsed    <= 16'd0;
        end
        KIND_STOP: begin
          running <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Current angles and the two stored poses
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        current_angles[i] <= home_angle(2'(i));
        pose_store[i]     <= home_angle(2'(i));
        pose_store[i + 4] <= home_angle(2'(i));
      end
    end else if (go) begin
      if (kind == KIND_MOVE) begin
        current_angles[joint] <= move_angle;
      end else if (kind == KIND_SAVE) begin
        for (int i = 0; i < 4; i++) begin
          pose_store[{pose_sel, 2'(i)}] <= current_angles[i];
        end
      end
    end
  end

endmodule

### rtl/core/tpss_out_reg.sv
// Output register of the playback sequencer: holds one result item until the
// master side takes it. Depends on tpss_pkg.
module tpss_out_reg
  import tpss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  result_t               res,
  output logic                  room,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // [1:0] out_joint, [9:2] out_angle
);

  logic [1:0] out_joint;
  logic [7:0] out_angle;

  assign room         = ~m_axis_tvalid | m_axis_tready;
  assign m_axis_tdata = {{(OUT_DATA_W - 10){1'b0}}, out_angle, out_joint};

  // Load a new result when the register is free or being emptied
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (room) begin
      m_axis_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (room && res.valid) begin
      out_joint <= res.joint;
      out_angle <= res.angle;
    end
  end

endmodule

### rtl/core/two_pose_servo_playback_sequencer.sv
// Top level of the two-pose servo playback sequencer: input register, core
// update and output register. Depends on tpss_pkg, tpss_core, tpss_out_reg.
//
// Usage:
//   Slave-side stream carries one item per transfer: tuser holds the kind
//   (tick, move, save, start, stop), tdata the joint, angle and pose select.
//   Master-side stream carries joint commands (joint and angle) from move
//   items and from playback ticks that reach their step delay.
//   The configuration channel writes the step delay (index 0) and the hook
//   delay (index 1); it is always ready and should be used while idle.
// Path: an accepted item passes the input register, where the core updates
//   the state and forms its result, then the output register, which
//   presents the result on the master side.
// Throughput: one item per cycle while the master side does not stall; each
//   item updates the state between the input register and the output register.
// Reset: clears both stream stages, stops playback and restores the home
//   angles in the current angles and both poses; delays return to 500/1000.
// Stall: while a result waits on the master side the input register still
//   takes one item; after that tready drops until the result is taken.
module two_pose_servo_playback_sequencer
  import tpss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [1:0] joint, [9:2] angle, [10] pose_sel
  input  logic [2:0]            s_axis_tuser,  // [2:0] kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [1:0] out_joint, [9:2] out_angle
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]           cfg_data
);

  logic       s1_valid;
  logic [2:0] s1_kind;
  logic [1:0] s1_joint;
  logic [7:0] s1_angle;
  logic       s1_sel;
  logic       room;
  logic       go;
  result_t    res;

  assign go            = s1_valid & room;
  assign s_axis_tready = ~s1_valid | room;
  assign cfg_ready     = 1'b1;

  // Input register: advance when it is empty or the output side can take the result
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_kind  <= s_axis_tuser;
      s1_joint <= s_axis_tdata[1:0];
      s1_angle <= s_axis_tdata[9:2];
      s1_sel   <= s_axis_tdata[10];
    end
  end

  tpss_core u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .kind      (s1_kind),
    .joint     (s1_joint),
    .angle     (s1_angle),
    .pose_sel  (s1_sel),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .res       (res)
  );

  tpss_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .res           (res),
    .room          (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
